// ===== rtl/satlb_pkg.sv =====
package satlb_pkg;

  localparam int FIELD_W     = 48;
  localparam int AGE_OUT_W   = 3;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

  // input beat layout
  localparam int IN_OP_LSB  = 0;
  localparam int IN_VA_LSB  = 2;
  localparam int IN_WP_LSB  = 50;
  localparam int IN_FLT_BIT = 98;

  // result beat layout
  localparam int OUT_ST_LSB  = 0;
  localparam int OUT_PA_LSB  = 2;
  localparam int OUT_AGE_LSB = 50;
  localparam int OUT_WR_LSB  = 53;
  localparam int OUT_PAD_LSB = 101;

  typedef enum logic [1:0] {
    OP_XLATE  = 2'd0,
    OP_REFILL = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FAULT = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

endpackage

// ===== rtl/satlb_ram.sv =====
module satlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/set_assoc_tlb_age_lru.sv =====
// an input beat is held in the input stage, then its result in the result register
// throughput: one beat per cycle unless stalled; ways are read in parallel from per-way
// rams, the last write is forwarded, so back-to-back beats to one set see fresh entries
// reset: synchronous, active low; clears all valid bits and pipeline valids at once,
// so the buffer is usable in the first cycle after reset with no clearing pass
module set_assoc_tlb_age_lru
  import satlb_pkg::*;
#(
  parameter int NUM_SETS         = 16,  // power of two
  parameter int NUM_WAYS         = 4,
  parameter int PAGE_OFFSET_BITS = 12,
  parameter int ADDR_BITS        = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode, virt_addr, walk_page_addr, walk_fault, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, phys_addr, age_rank, walk_request_addr, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int VPN_W = ADDR_BITS - PAGE_OFFSET_BITS;
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int AGE_W = $clog2(NUM_WAYS + 1);
  localparam int ENT_W = AGE_W + 2 * VPN_W;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [VPN_W-1:0] vpn;
    logic [VPN_W-1:0] ppn;
  } ent_t;

  // input stage
  logic                 s1_valid_r, s1_valid_nxt;
  opcode_t              s1_op_r, s1_op_nxt;
  logic [ADDR_BITS-1:0] s1_va_r, s1_va_nxt;
  logic [ADDR_BITS-1:0] s1_wp_r, s1_wp_nxt;
  logic                 s1_fault_r, s1_fault_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]   out_pa_r, out_pa_nxt;
  logic [AGE_OUT_W-1:0] out_age_r, out_age_nxt;
  logic [FIELD_W-1:0]   out_wreq_r, out_wreq_nxt;

  // valid bits, one per entry
  logic [NUM_WAYS-1:0] vld_r [NUM_SETS];
  logic [NUM_WAYS-1:0] vld_nxt [NUM_SETS];

  // last ram write, forwarded to a read issued in the same cycle
  logic [NUM_WAYS-1:0] fwd_we_r, fwd_we_nxt;
  logic [SET_W-1:0]    fwd_set_r, fwd_set_nxt;
  ent_t                fwd_ent_r [NUM_WAYS];
  ent_t                fwd_ent_nxt [NUM_WAYS];

  logic                 in_fire, adv;
  logic [ADDR_BITS-1:0] in_va;
  logic [SET_W-1:0]     in_set;

  logic [VPN_W-1:0]            s1_vpn, s1_wvpn;
  logic [PAGE_OFFSET_BITS-1:0] s1_off;
  logic [SET_W-1:0]            s1_set;
  logic [NUM_WAYS-1:0]         s1_vld;

  ent_t                ram_q [NUM_WAYS];
  ent_t                rd_ent [NUM_WAYS];
  logic [AGE_W-1:0]    eff_age [NUM_WAYS];
  logic [NUM_WAYS-1:0] hit_vec;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    vic_way;
  logic                vic_found;
  logic [WAY_W-1:0]    tgt_way;
  logic                touch_en;
  logic [NUM_WAYS-1:0] we_vec;
  ent_t                wr_ent [NUM_WAYS];
  logic                vld_any;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  assign in_va  = ADDR_BITS'(in_tdata[IN_VA_LSB +: FIELD_W]);
  assign in_set = SET_W'(in_va[ADDR_BITS-1:PAGE_OFFSET_BITS] & VPN_W'(NUM_SETS - 1));

  assign s1_vpn  = s1_va_r[ADDR_BITS-1:PAGE_OFFSET_BITS];
  assign s1_off  = s1_va_r[PAGE_OFFSET_BITS-1:0];
  assign s1_wvpn = s1_wp_r[ADDR_BITS-1:PAGE_OFFSET_BITS];
  assign s1_set  = SET_W'(s1_vpn & VPN_W'(NUM_SETS - 1));
  assign s1_vld  = vld_r[s1_set];

  // one ram per way, addressed by set
  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_way
    satlb_ram #(
      .WIDTH(ENT_W),
      .DEPTH(NUM_SETS)
    ) u_ram (
      .clk  (clk),
      .we   (we_vec[g]),
      .waddr(s1_set),
      .wdata(wr_ent[g]),
      .re   (in_fire),
      .raddr(in_set),
      .rdata(ram_q[g])
    );
  end

  // way read, compare and victim pick
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rd_ent[w]  = (fwd_we_r[w] && fwd_set_r == s1_set) ? fwd_ent_r[w] : ram_q[w];
      eff_age[w] = s1_vld[w] ? rd_ent[w].age : '0;
      hit_vec[w] = s1_vld[w] && rd_ent[w].vpn == s1_vpn;
    end
    hit_any = |hit_vec;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    vic_way   = '0;
    vic_found = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!vic_found && !s1_vld[w]) begin
        vic_way   = WAY_W'(w);
        vic_found = 1'b1;
      end
    end
    if (!vic_found) begin
      for (int w = 1; w < NUM_WAYS; w++) begin
        if (eff_age[w] > eff_age[vic_way]) begin
          vic_way = WAY_W'(w);
        end
      end
    end
  end

  // result and state update
  always_comb begin
    out_status_nxt = ST_DONE;
    out_pa_nxt     = '0;
    out_age_nxt    = '0;
    out_wreq_nxt   = '0;
    touch_en       = 1'b0;
    tgt_way        = hit_any ? hit_way : vic_way;
    unique case (s1_op_r)
      OP_XLATE: begin
        if (hit_any) begin
          touch_en       = 1'b1;
          out_status_nxt = ST_OK;
          out_pa_nxt     = FIELD_W'({rd_ent[hit_way].ppn, s1_off});
        end else begin
          out_status_nxt = ST_MISS;
          out_wreq_nxt   = FIELD_W'({s1_vpn, {PAGE_OFFSET_BITS{1'b0}}});
        end
      end
      OP_REFILL: begin
        if (s1_fault_r) begin
          out_status_nxt = ST_FAULT;
        end else begin
          touch_en       = 1'b1;
          out_status_nxt = ST_OK;
          out_pa_nxt     = FIELD_W'({s1_wvpn, s1_off});
        end
      end
      OP_PEEK: begin
        if (hit_any) begin
          out_age_nxt = AGE_OUT_W'(eff_age[hit_way]);
        end
      end
      OP_CLEAR: begin
      end
    endcase

    for (int w = 0; w < NUM_WAYS; w++) begin
      wr_ent[w] = rd_ent[w];
      if (s1_vld[w] && eff_age[w] < AGE_W'(NUM_WAYS)) begin
        wr_ent[w].age = eff_age[w] + AGE_W'(1);
      end else begin
        wr_ent[w].age = eff_age[w];
      end
      if (WAY_W'(w) == tgt_way) begin
        wr_ent[w].age = AGE_W'(1);
        if (s1_op_r == OP_REFILL) begin
          wr_ent[w].vpn = s1_vpn;
          wr_ent[w].ppn = s1_wvpn;
        end
      end
      we_vec[w] = adv && touch_en && (s1_vld[w] || WAY_W'(w) == tgt_way);
    end

    vld_nxt = vld_r;
    if (adv && s1_op_r == OP_CLEAR) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        vld_nxt[s] = '0;
      end
    end else if (adv && s1_op_r == OP_REFILL && !s1_fault_r) begin
      vld_nxt[s1_set][tgt_way] = 1'b1;
    end

    vld_any = 1'b0;
    for (int s = 0; s < NUM_SETS; s++) begin
      vld_any = vld_any | (|vld_r[s]);
    end
  end

  // pipeline next values
  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    s1_op_nxt    = in_fire ? opcode_t'(in_tdata[IN_OP_LSB +: 2]) : s1_op_r;
    s1_va_nxt    = in_fire ? in_va : s1_va_r;
    s1_wp_nxt    = in_fire ? ADDR_BITS'(in_tdata[IN_WP_LSB +: FIELD_W]) : s1_wp_r;
    s1_fault_nxt = in_fire ? in_tdata[IN_FLT_BIT] : s1_fault_r;

    out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

    fwd_we_nxt  = adv ? we_vec : fwd_we_r;
    fwd_set_nxt = adv ? s1_set : fwd_set_r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      fwd_ent_nxt[w] = adv ? wr_ent[w] : fwd_ent_r[w];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_op_r     <= OP_XLATE;
      out_valid_r <= 1'b0;
      fwd_we_r    <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        vld_r[s] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_op_r     <= s1_op_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_we_r    <= fwd_we_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_va_r    <= s1_va_nxt;
    s1_wp_r    <= s1_wp_nxt;
    s1_fault_r <= s1_fault_nxt;
    fwd_set_r  <= fwd_set_nxt;
    fwd_ent_r  <= fwd_ent_nxt;
    if (adv) begin
      out_status_r <= out_status_nxt;
      out_pa_r     <= out_pa_nxt;
      out_age_r    <= out_age_nxt;
      out_wreq_r   <= out_wreq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    {(OUT_TDATA_W - OUT_PAD_LSB){1'b0}},
    out_wreq_r,
    out_age_r,
    out_pa_r,
    out_status_r
  };

`ifndef SYNTHESIS
  a_no_dup_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(hit_vec))
    else $error("more than one way hits in a set");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_CLEAR) |=> !vld_any)
    else $error("valid bits left after clear");

  a_refill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_REFILL && !s1_fault_r) |=> vld_r[$past(s1_set)][$past(tgt_way)])
    else $error("refilled way not valid");
`endif

endmodule

// ===== sim/testbench.sv =====
import satlb_pkg::*;

localparam int ADDR_W = FIELD_W;
localparam int OFF_W  = 12;
localparam int PAGE_W = ADDR_W - OFF_W;
localparam int NSETS  = 16;
localparam int NWAYS  = 4;
localparam int PAD_W  = OUT_TDATA_W - OUT_PAD_LSB;

typedef struct {
  opcode_t           op;
  logic [ADDR_W-1:0] va;
  logic [ADDR_W-1:0] walk_pa;
  logic              walk_flt;
} tlb_req_t;

typedef struct {
  status_t           st;
  logic [ADDR_W-1:0] pa;
  logic [2:0]        age;
  logic [ADDR_W-1:0] walk_req;
  logic [PAD_W-1:0]  pad;
} tlb_resp_t;

class tlb_scoreboard;
  bit              vld   [NSETS][NWAYS];
  bit [PAGE_W-1:0] vpage [NSETS][NWAYS];
  bit [PAGE_W-1:0] ppage [NSETS][NWAYS];
  bit [2:0]        age   [NSETS][NWAYS];
  tlb_resp_t       pending_results[$];
  int              errors;

  function int pending();
    return pending_results.size();
  endfunction

  // valid ways grow older, saturating, and the used way becomes the youngest
  function void refresh_ages(int set_idx, int used_way);
    for (int w = 0; w < NWAYS; w++) begin
      if (vld[set_idx][w] && age[set_idx][w] < NWAYS) age[set_idx][w]++;
    end
    age[set_idx][used_way] = 3'd1;
  endfunction

  function int find_way(int set_idx, bit [PAGE_W-1:0] pg);
    for (int w = 0; w < NWAYS; w++) begin
      if (vld[set_idx][w] && vpage[set_idx][w] == pg) return w;
    end
    return -1;
  endfunction

  function int pick_victim(int set_idx);
    int oldest;
    oldest = 0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!vld[set_idx][w]) return w;
    end
    for (int w = 1; w < NWAYS; w++) begin
      if (age[set_idx][w] > age[set_idx][oldest]) oldest = w;
    end
    return oldest;
  endfunction

  task note_request(tlb_req_t r);
    tlb_resp_t       res;
    bit [PAGE_W-1:0] pg;
    bit [OFF_W-1:0]  off;
    int              set_idx;
    int              way;
    pg      = r.va[ADDR_W-1:OFF_W];
    off     = r.va[OFF_W-1:0];
    set_idx = int'(pg[3:0]);
    way     = find_way(set_idx, pg);
    res.st       = ST_DONE;
    res.pa       = '0;
    res.age      = '0;
    res.walk_req = '0;
    res.pad      = '0;
    case (r.op)
      OP_XLATE: begin
        if (way >= 0) begin
          refresh_ages(set_idx, way);
          res.pa = {ppage[set_idx][way], off};
          res.st = ST_OK;
        end else begin
          res.walk_req = {pg, {OFF_W{1'b0}}};
          res.st       = ST_MISS;
        end
      end
      OP_REFILL: begin
        if (r.walk_flt) begin
          res.st = ST_FAULT;
        end else begin
          if (way < 0) way = pick_victim(set_idx);
          vpage[set_idx][way] = pg;
          ppage[set_idx][way] = r.walk_pa[ADDR_W-1:OFF_W];
          vld[set_idx][way]   = 1'b1;
          refresh_ages(set_idx, way);
          res.pa = {r.walk_pa[ADDR_W-1:OFF_W], off};
          res.st = ST_OK;
        end
      end
      OP_PEEK: begin
        if (way >= 0) res.age = age[set_idx][way];
      end
      default: begin
        for (int s = 0; s < NSETS; s++) begin
          for (int w = 0; w < NWAYS; w++) begin
            vld[s][w] = 1'b0;
            age[s][w] = '0;
          end
        end
      end
    endcase
    pending_results.push_back(res);
  endtask

  task report(string msg);
    errors++;
    if (errors <= 100) $display("mismatch: %s", msg);
  endtask

  task check_response(tlb_resp_t got);
    tlb_resp_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result beat, status %0d", got.st));
      return;
    end
    want = pending_results.pop_front();
    if (got.st !== want.st)
      report($sformatf("status %0d, want %0d", got.st, want.st));
    if (got.pa !== want.pa)
      report($sformatf("phys_addr %h, want %h", got.pa, want.pa));
    if (got.age !== want.age)
      report($sformatf("age_rank %0d, want %0d", got.age, want.age));
    if (got.walk_req !== want.walk_req)
      report($sformatf("walk_request_addr %h, want %h", got.walk_req, want.walk_req));
    if (got.pad !== want.pad)
      report($sformatf("pad bits %b, want zero", got.pad));
  endtask
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  tlb_scoreboard sb = new;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_toggle = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;
  int          sent = 0;
  logic [31:0] pool_tag [6];

  set_assoc_tlb_age_lru DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    tlb_req_t  rq;
    tlb_resp_t rs;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rq.op       = opcode_t'(in_tdata[IN_OP_LSB +: 2]);
        rq.va       = in_tdata[IN_VA_LSB +: ADDR_W];
        rq.walk_pa  = in_tdata[IN_WP_LSB +: ADDR_W];
        rq.walk_flt = in_tdata[IN_FLT_BIT];
        sb.note_request(rq);
      end
      if (out_tvalid && out_tready) begin
        rs.st       = status_t'(out_tdata[OUT_ST_LSB +: 2]);
        rs.pa       = out_tdata[OUT_PA_LSB +: ADDR_W];
        rs.age      = out_tdata[OUT_AGE_LSB +: AGE_OUT_W];
        rs.walk_req = out_tdata[OUT_WR_LSB +: ADDR_W];
        rs.pad      = out_tdata[OUT_PAD_LSB +: PAD_W];
        sb.check_response(rs);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rnd48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic tlb_req_t mk(opcode_t op, logic [ADDR_W-1:0] va,
                                  logic [ADDR_W-1:0] walk_pa, logic walk_flt);
    tlb_req_t r;
    r.op       = op;
    r.va       = va;
    r.walk_pa  = walk_pa;
    r.walk_flt = walk_flt;
    return r;
  endfunction

  // a few tags per set, more than the ways, so lookups hit and sets overflow
  function automatic logic [ADDR_W-1:0] pool_addr();
    return {pool_tag[$urandom_range(5)], 4'($urandom_range(15)), 12'($urandom)};
  endfunction

  task automatic send(tlb_req_t r);
    logic [IN_TDATA_W-1:0] beat;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    beat = '0;
    beat[IN_OP_LSB +: 2]      = r.op;
    beat[IN_VA_LSB +: ADDR_W] = r.va;
    beat[IN_WP_LSB +: ADDR_W] = r.walk_pa;
    beat[IN_FLT_BIT]          = r.walk_flt;
    in_tdata  <= beat;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // wait on the clock first so the last accepted beat is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    logic [ADDR_W-1:0] top;
    logic [ADDR_W-1:0] va;
    top = '1;
    send(mk(OP_XLATE, '0, '0, 1'b0));
    send(mk(OP_PEEK, '0, '0, 1'b0));
    send(mk(OP_REFILL, '0, top, 1'b0));
    send(mk(OP_XLATE, 48'h0000_0000_0fff, '0, 1'b0));
    send(mk(OP_PEEK, '0, top, 1'b1));
    send(mk(OP_REFILL, top, top, 1'b1));
    send(mk(OP_XLATE, top, '0, 1'b0));
    send(mk(OP_REFILL, top, '0, 1'b0));
    send(mk(OP_XLATE, top, top, 1'b1));
    // overflow one set so the oldest way is evicted
    for (int k = 0; k < 5; k++) begin
      va = {32'(k + 1), 4'd5, 12'(k * 291)};
      send(mk(OP_REFILL, va, {36'(k * 7 + 3), 12'hfff}, 1'b0));
    end
    send(mk(OP_PEEK, {32'd2, 4'd5, 12'h0}, '0, 1'b0));
    send(mk(OP_XLATE, {32'd1, 4'd5, 12'h123}, '0, 1'b0));
    // refill of a resident page rewrites it in place
    send(mk(OP_REFILL, {32'd3, 4'd5, 12'h0}, 48'h5555_5555_5000, 1'b0));
    send(mk(OP_XLATE, {32'd3, 4'd5, 12'habc}, top, 1'b0));
    send(mk(OP_PEEK, {32'd3, 4'd5, 12'h0}, top, 1'b1));
    send(mk(OP_PEEK, {32'd4, 4'd5, 12'h0}, '0, 1'b0));
    send(mk(OP_CLEAR, top, top, 1'b1));
    send(mk(OP_XLATE, '0, '0, 1'b0));
    send(mk(OP_PEEK, top, '0, 1'b0));
    send(mk(OP_XLATE, {32'd3, 4'd5, 12'h0}, '0, 1'b0));
  endtask

  task automatic random_traffic(int upto);
    logic [ADDR_W-1:0] va;
    int                pick;
    while (sent < upto) begin
      pick = $urandom_range(99);
      va   = pool_addr();
      if (pick < 55) begin
        // look up, refill from a walk, then look up again with a new offset
        send(mk(OP_XLATE, va, rnd48(), 1'($urandom)));
        send(mk(OP_REFILL, va, rnd48(), $urandom_range(9) == 0));
        send(mk(OP_XLATE, {va[ADDR_W-1:OFF_W], 12'($urandom)}, rnd48(), 1'($urandom)));
        if (pick < 20) send(mk(OP_PEEK, va, rnd48(), 1'($urandom)));
      end else if (pick < 72) begin
        send(mk(OP_XLATE, va, rnd48(), 1'($urandom)));
      end else if (pick < 84) begin
        send(mk(OP_PEEK, va, rnd48(), 1'($urandom)));
      end else if (pick < 85) begin
        send(mk(OP_CLEAR, rnd48(), rnd48(), 1'($urandom)));
      end else begin
        send(mk(opcode_t'($urandom_range(2)), rnd48(), rnd48(), 1'($urandom)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) pool_tag[i] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 7;
    rx_idle_pct <= 58;
    directed_items();
    in_tvalid <= 1'b0;
    wait_drained();
    random_traffic(470);

    tx_idle_pct = 58;
    rx_idle_pct <= 7;
    random_traffic(900);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_toggle <= ~hold_toggle;
    random_traffic(960);
    in_tvalid <= 1'b0;
    wait_drained();
    random_traffic(1330);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/satlb_pkg.sv
rtl/satlb_ram.sv
rtl/set_assoc_tlb_age_lru.sv
sim/testbench.sv
